>>> rtl/polrect_pkg.sv
`default_nettype none
package polrect_pkg;

  localparam int AMP_W   = 16;
  localparam int ANG_W   = 16;
  localparam int OUT_W   = AMP_W + 1;
  localparam int ITER    = 30;
  localparam int GUARD   = 28;
  localparam int TURN_W  = 32;
  localparam int PROD_W  = AMP_W + TURN_W;
  localparam int X0_W    = PROD_W - (TURN_W - GUARD);
  localparam int COORD_W = X0_W + 3;
  localparam int Z_W     = TURN_W + 1;
  localparam int RND_W   = COORD_W - GUARD;

  localparam logic [TURN_W-1:0] INV_GAIN = 32'h9B74EDA8;
  localparam logic signed [COORD_W-1:0] RND_HALF = COORD_W'(1) << (GUARD - 1);
  localparam logic signed [RND_W-1:0] OUT_LIM = RND_W'((1 << AMP_W) - 1);

  typedef struct packed {
    logic valid;
    logic flip;
  } polrect_ctl_t;

  function automatic logic [TURN_W-1:0] atan_turn(input int idx);
    logic [TURN_W-1:0] r;
    case (idx)
      0:  r = 32'h20000000;
      1:  r = 32'h12E4051E;
      2:  r = 32'h09FB385B;
      3:  r = 32'h051111D4;
      4:  r = 32'h028B0D43;
      5:  r = 32'h0145D7E1;
      6:  r = 32'h00A2F61E;
      7:  r = 32'h00517C55;
      8:  r = 32'h0028BE53;
      9:  r = 32'h00145F2F;
      10: r = 32'h000A2F98;
      11: r = 32'h000517CC;
      12: r = 32'h00028BE6;
      13: r = 32'h000145F3;
      14: r = 32'h0000A2FA;
      15: r = 32'h0000517D;
      16: r = 32'h000028BE;
      17: r = 32'h0000145F;
      18: r = 32'h00000A30;
      19: r = 32'h00000518;
      20: r = 32'h0000028C;
      21: r = 32'h00000146;
      22: r = 32'h000000A3;
      23: r = 32'h00000051;
      24: r = 32'h00000029;
      25: r = 32'h00000014;
      26: r = 32'h0000000A;
      27: r = 32'h00000005;
      28: r = 32'h00000003;
      29: r = 32'h00000001;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/polrect_rotator.sv
`default_nettype none
module polrect_rotator (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  input  wire polrect_pkg::polrect_ctl_t                 ctl_in,
  input  wire logic signed [polrect_pkg::COORD_W-1:0]    x_in,
  input  wire logic signed [polrect_pkg::Z_W-1:0]        z_in,
  output polrect_pkg::polrect_ctl_t                      ctl_out,
  output logic signed [polrect_pkg::COORD_W-1:0]         x_out,
  output logic signed [polrect_pkg::COORD_W-1:0]         y_out
);

  polrect_pkg::polrect_ctl_t                  ctl [0:polrect_pkg::ITER];
  logic signed [polrect_pkg::COORD_W-1:0]     x   [0:polrect_pkg::ITER];
  logic signed [polrect_pkg::COORD_W-1:0]     y   [0:polrect_pkg::ITER];
  logic signed [polrect_pkg::Z_W-1:0]         z   [0:polrect_pkg::ITER];

  assign ctl[0] = ctl_in;
  assign x[0]   = x_in;
  assign y[0]   = '0;
  assign z[0]   = z_in;

  for (genvar i = 0; i < polrect_pkg::ITER; i++) begin : g_iter
    logic signed [polrect_pkg::COORD_W-1:0] dx;
    logic signed [polrect_pkg::COORD_W-1:0] dy;
    logic signed [polrect_pkg::Z_W-1:0]     da;

    assign dx = x[i] >>> i;
    assign dy = y[i] >>> i;
    assign da = $signed({1'b0, polrect_pkg::atan_turn(i)});

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl[i+1].valid <= 1'b0;
      end else begin
        ctl[i+1].valid <= ctl[i].valid;
      end
      ctl[i+1].flip <= ctl[i].flip;
      if (!z[i][polrect_pkg::Z_W-1]) begin
        x[i+1] <= x[i] - dy;
        y[i+1] <= y[i] + dx;
        z[i+1] <= z[i] - da;
      end else begin
        x[i+1] <= x[i] + dy;
        y[i+1] <= y[i] - dx;
        z[i+1] <= z[i] + da;
      end
    end
  end

  assign ctl_out = ctl[polrect_pkg::ITER];
  assign x_out   = x[polrect_pkg::ITER];
  assign y_out   = y[polrect_pkg::ITER];

endmodule
`default_nettype wire

>>> rtl/polar_to_rectangular.sv
`default_nettype none
// Polar to rectangular converter for image samples, CORDIC in rotation mode.
// Input: pulse start with amplitude (unsigned) and phase (binary angle,
// 32768 = pi) in the same cycle; a transfer happens whenever start is high
// and busy is low. busy stays low: the pipeline takes one sample every cycle.
// Output: done is high for exactly one cycle with real_part and imag_part,
// the amplitude times cosine and sine of the phase, rounded to nearest.
// Pipeline: one stage for the gain-compensation multiply, one stage per CORDIC
// iteration (30), one for rounding and one for sign and clamp.
// Throughput: one sample per cycle, in order, set by the one-iteration-per-
// stage rotator.
// Reset: clears every valid bit in the pipeline; samples in flight are
// dropped and done stays low until new samples arrive.
// The receiver cannot stall: results are shown for one cycle only.
module polar_to_rectangular (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   start,
  output logic                                        busy,
  input  wire logic        [polrect_pkg::AMP_W-1:0]   amplitude,
  input  wire logic signed [polrect_pkg::ANG_W-1:0]   phase,
  output logic                                        done,
  output logic signed      [polrect_pkg::OUT_W-1:0]   real_part,
  output logic signed      [polrect_pkg::OUT_W-1:0]   imag_part
);

  logic [polrect_pkg::PROD_W-1:0]             prod;
  logic [polrect_pkg::TURN_W-1:0]             ang;
  logic                                       flip_in;
  logic [polrect_pkg::TURN_W-1:0]             ang_fold;

  polrect_pkg::polrect_ctl_t                  ctl0;
  logic signed [polrect_pkg::COORD_W-1:0]     x0;
  logic signed [polrect_pkg::Z_W-1:0]         z0;

  polrect_pkg::polrect_ctl_t                  ctl_rot;
  logic signed [polrect_pkg::COORD_W-1:0]     x_rot;
  logic signed [polrect_pkg::COORD_W-1:0]     y_rot;

  logic signed [polrect_pkg::COORD_W-1:0]     x_sum;
  logic signed [polrect_pkg::COORD_W-1:0]     y_sum;
  polrect_pkg::polrect_ctl_t                  ctl_rnd;
  logic signed [polrect_pkg::RND_W-1:0]       x_rnd;
  logic signed [polrect_pkg::RND_W-1:0]       y_rnd;

  logic signed [polrect_pkg::RND_W-1:0]       x_neg;
  logic signed [polrect_pkg::RND_W-1:0]       y_neg;
  logic signed [polrect_pkg::RND_W-1:0]       x_sat;
  logic signed [polrect_pkg::RND_W-1:0]       y_sat;
  logic signed [polrect_pkg::OUT_W-1:0]       real_part_next;
  logic signed [polrect_pkg::OUT_W-1:0]       imag_part_next;

  assign busy = 1'b0;

  assign prod = {{polrect_pkg::TURN_W{1'b0}}, amplitude}
              * {{polrect_pkg::AMP_W{1'b0}}, polrect_pkg::INV_GAIN};

  // fold the angle into the right half plane and flip the result
  assign ang      = {phase, {(polrect_pkg::TURN_W - polrect_pkg::ANG_W){1'b0}}};
  assign flip_in  = ang[polrect_pkg::TURN_W-1] ^ ang[polrect_pkg::TURN_W-2];
  assign ang_fold = {ang[polrect_pkg::TURN_W-1] ^ flip_in, ang[polrect_pkg::TURN_W-2:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl0.valid <= 1'b0;
    end else begin
      ctl0.valid <= start && !busy;
    end
    ctl0.flip <= flip_in;
    x0 <= $signed({{(polrect_pkg::COORD_W - polrect_pkg::X0_W){1'b0}},
                   prod[polrect_pkg::PROD_W-1:polrect_pkg::TURN_W-polrect_pkg::GUARD]});
    z0 <= $signed({ang_fold[polrect_pkg::TURN_W-1], ang_fold});
  end

  polrect_rotator u_rotator (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (ctl0),
    .x_in    (x0),
    .z_in    (z0),
    .ctl_out (ctl_rot),
    .x_out   (x_rot),
    .y_out   (y_rot)
  );

  assign x_sum = x_rot + polrect_pkg::RND_HALF;
  assign y_sum = y_rot + polrect_pkg::RND_HALF;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_rnd.valid <= 1'b0;
    end else begin
      ctl_rnd.valid <= ctl_rot.valid;
    end
    ctl_rnd.flip <= ctl_rot.flip;
    x_rnd <= x_sum[polrect_pkg::COORD_W-1:polrect_pkg::GUARD];
    y_rnd <= y_sum[polrect_pkg::COORD_W-1:polrect_pkg::GUARD];
  end

  always_comb begin
    x_neg = ctl_rnd.flip ? -x_rnd : x_rnd;
    y_neg = ctl_rnd.flip ? -y_rnd : y_rnd;
    if (x_neg > polrect_pkg::OUT_LIM) begin
      x_sat = polrect_pkg::OUT_LIM;
    end else if (x_neg < -polrect_pkg::OUT_LIM) begin
      x_sat = -polrect_pkg::OUT_LIM;
    end else begin
      x_sat = x_neg;
    end
    if (y_neg > polrect_pkg::OUT_LIM) begin
      y_sat = polrect_pkg::OUT_LIM;
    end else if (y_neg < -polrect_pkg::OUT_LIM) begin
      y_sat = -polrect_pkg::OUT_LIM;
    end else begin
      y_sat = y_neg;
    end
    real_part_next = x_sat[polrect_pkg::OUT_W-1:0];
    imag_part_next = y_sat[polrect_pkg::OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl_rnd.valid;
    end
    real_part <= real_part_next;
    imag_part <= imag_part_next;
  end

endmodule
`default_nettype wire

>>> verif/polar_to_rectangular_tb.sv
`default_nettype none
module polar_to_rectangular_tb;

  localparam int FRAC_BITS  = 28;
  localparam int STAGES     = 30;
  localparam int CYCLE_LIMIT = 300000;
  localparam int TAIL_CYCLES = 40;
  localparam logic [63:0] GAIN_COMP = 64'h9B74_EDA8;
  localparam logic [31:0] ATAN_STEP [0:STAGES-1] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  typedef struct packed {
    logic signed [polrect_pkg::OUT_W-1:0] re;
    logic signed [polrect_pkg::OUT_W-1:0] im;
  } rect_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [polrect_pkg::AMP_W-1:0] amplitude = '0;
  logic signed [polrect_pkg::ANG_W-1:0] phase = '0;
  logic busy;
  logic done;
  logic signed [polrect_pkg::OUT_W-1:0] real_part;
  logic signed [polrect_pkg::OUT_W-1:0] imag_part;

  rect_t pending_rect[$];
  int mismatches = 0;
  int cycles = 0;
  int gap_max = 0;

  polar_to_rectangular u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .amplitude(amplitude),
    .phase(phase),
    .done(done),
    .real_part(real_part),
    .imag_part(imag_part)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic signed [polrect_pkg::OUT_W-1:0] round_coord(input longint v,
                                                                        input logic flip);
    longint r;
    longint lim;
    lim = (longint'(1) << polrect_pkg::AMP_W) - 1;
    r = (v + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (flip) r = -r;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r[polrect_pkg::OUT_W-1:0];
  endfunction

  function automatic rect_t polar_to_rect(input logic [polrect_pkg::AMP_W-1:0] amp,
                                          input logic [polrect_pkg::ANG_W-1:0] ph);
    logic [31:0] turn;
    logic [63:0] prod;
    logic flip;
    longint x, y, z, dx, dy;
    rect_t r;
    turn = 32'(ph) << (32 - polrect_pkg::ANG_W);
    flip = turn[31] ^ turn[30];
    if (flip) turn = turn + 32'h8000_0000;
    z = longint'(signed'(turn));
    prod = 64'(amp) * GAIN_COMP;
    x = longint'(prod >> (32 - FRAC_BITS));
    y = 0;
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(ATAN_STEP[i]);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(ATAN_STEP[i]);
      end
    end
    r.re = round_coord(x, flip);
    r.im = round_coord(y, flip);
    return r;
  endfunction

  // hold start until the transfer, then optionally drop it for a random gap
  task automatic send_sample(input logic [polrect_pkg::AMP_W-1:0] amp,
                             input logic [polrect_pkg::ANG_W-1:0] ph);
    int gap;
    gap = $urandom_range(0, gap_max);
    start <= 1'b1;
    amplitude <= amp;
    phase <= ph;
    do @(posedge clk); while (busy);
    pending_rect.push_back(polar_to_rect(amp, ph));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_for_drain();
    while (pending_rect.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    rect_t want;
    if (!rst && done) begin
      if (pending_rect.size() == 0) begin
        $display("%0t unexpected result: real_part %0d imag_part %0d",
                 $time, real_part, imag_part);
        mismatches++;
      end else begin
        want = pending_rect.pop_front();
        if (real_part !== want.re) begin
          $display("%0t real_part expected %0d got %0d", $time, want.re, real_part);
          mismatches++;
        end
        if (imag_part !== want.im) begin
          $display("%0t imag_part expected %0d got %0d", $time, want.im, imag_part);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic test_directed_corners();
    logic [polrect_pkg::AMP_W-1:0] amps [0:2];
    logic [polrect_pkg::ANG_W-1:0] phs [0:6];
    amps = '{16'hFFFF, 16'd0, 16'd1};
    phs = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'h3FFF, 16'h7FFF, 16'hBFFF};
    gap_max = 0;
    foreach (phs[p]) send_sample(amps[0], phs[p]);
    send_sample(amps[1], 16'h2000);
    send_sample(amps[1], 16'hE000);
    send_sample(amps[2], 16'h6000);
    send_sample(amps[2], 16'hA000);
    send_sample(16'h8000, 16'h2000);
    send_sample(16'hFFFF, 16'h2000);
    send_sample(16'hFFFF, 16'hC001);
    send_sample(16'hFFFF, 16'h4001);
    send_sample(16'h0003, 16'h1555);
    send_sample(16'h7FFF, 16'h8001);
    start <= 1'b0;
    wait_for_drain();
  endtask

  task automatic test_random_samples(input int count);
    logic [polrect_pkg::AMP_W-1:0] amp;
    logic [polrect_pkg::ANG_W-1:0] ph;
    for (int n = 0; n < count; n++) begin
      if (n % 60 == 0) begin
        case ($urandom_range(0, 2))
          0: gap_max = 0;
          1: gap_max = 13;
          default: gap_max = 2;
        endcase
      end
      case ($urandom_range(0, 3))
        0: amp = polrect_pkg::AMP_W'($urandom_range(0, 15));
        1: amp = polrect_pkg::AMP_W'(16'hFFFF - $urandom_range(0, 15));
        default: amp = polrect_pkg::AMP_W'($urandom);
      endcase
      if ($urandom_range(0, 3) == 0)
        ph = polrect_pkg::ANG_W'(($urandom_range(0, 7) << 13) + $urandom_range(0, 8) - 4);
      else
        ph = polrect_pkg::ANG_W'($urandom);
      send_sample(amp, ph);
    end
    start <= 1'b0;
  endtask

  task automatic test_pause_for_drain();
    gap_max = 0;
    for (int n = 0; n < 40; n++) begin
      send_sample(polrect_pkg::AMP_W'($urandom), polrect_pkg::ANG_W'($urandom));
      if (n == 19) begin
        start <= 1'b0;
        wait_for_drain();
      end
    end
    start <= 1'b0;
    wait_for_drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed_corners();
    test_pause_for_drain();
    test_random_samples(1750);
    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
`default_nettype wire

>>> files.f
rtl/polrect_pkg.sv
rtl/polrect_rotator.sv
rtl/polar_to_rectangular.sv
verif/polar_to_rectangular_tb.sv
